// File: hw/rtl/page_buffer_lru_pin_dirty_assert.svh
// Assertion macros for the checker file pblru_checker.
`ifndef PAGE_BUFFER_LRU_PIN_DIRTY_ASSERT_SVH
`define PAGE_BUFFER_LRU_PIN_DIRTY_ASSERT_SVH
// Check an implication on every clock edge, off during reset.
`define PB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check an implication in the following cycle.
`define PB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/pblru_pkg.sv
// ----------------------------------------------------------------------------
// pblru_pkg
// Shared types and codes of the page-frame directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pblru_pkg;
	localparam int FRAMES_DEF = 16;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_FLUSH  = 3'd2,
		OP_PIN    = 3'd3,
		OP_UNPIN  = 3'd4,
		OP_REMOVE = 3'd5,
		OP_DROP   = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_PINNED = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] file_id;
		logic [31:0] page_num;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  frame;
		logic        hit;
		logic        fetch;
		logic        writeback;
		logic [15:0] wb_file;
		logic [31:0] wb_page;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Commands from the controller into every cell.
	typedef struct packed {
		logic        look;   // high during the scan; unused by the cells
		logic        commit; // apply phase
		logic [2:0]  op;
		logic        fill;   // apply a fill to the selected frame
		logic [15:0] file_id;
		logic [31:0] page_num;
		logic [31:0] stamp;
	} cmd_t;

	// Chain data passed from cell to cell (lower index first).
	typedef struct packed {
		logic        found;      // a matching frame lies earlier
		logic        empty;      // an empty frame lies earlier
		logic        cand;       // an unpinned valid frame lies earlier
		logic        any_drop;
		logic [5:0]  hit_idx;
		logic [5:0]  empty_idx;
		logic [5:0]  cand_idx;
		logic [31:0] cand_stamp;
		logic [15:0] cand_file;
		logic [31:0] cand_page;
	} chain_t;
endpackage
`default_nettype wire

// File: hw/rtl/pblru_cell.sv
// ----------------------------------------------------------------------------
// pblru_cell
// One frame of the directory: tags, marks, stamp and a chain stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pblru_cell #(
	parameter int IDX_W = 6,
	parameter logic [IDX_W-1:0] INDEX = '0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pblru_pkg::cmd_t   cmd,
	input  wire logic [IDX_W-1:0]  sel,
	input  wire pblru_pkg::chain_t chain_in,
	output pblru_pkg::chain_t      chain_out
);
	logic        valid_q, pinned_q, dirty_q;
	logic [15:0] file_q;
	logic [31:0] page_q;
	logic [31:0] stamp_q;
	logic        match, fmatch, me;
	pblru_pkg::chain_t chain_d, chain_q;

	assign fmatch = valid_q && (file_q == cmd.file_id);
	assign match  = fmatch && (page_q == cmd.page_num);
	assign me     = (sel == INDEX);

	always_comb begin
		chain_d = chain_in;
		if (match && !chain_in.found) begin
			chain_d.found   = 1'b1;
			chain_d.hit_idx = 6'(INDEX);
		end
		if (!valid_q && !chain_in.empty) begin
			chain_d.empty     = 1'b1;
			chain_d.empty_idx = 6'(INDEX);
		end
		if (valid_q && !pinned_q &&
				(!chain_in.cand || stamp_q < chain_in.cand_stamp)) begin
			chain_d.cand       = 1'b1;
			chain_d.cand_idx   = 6'(INDEX);
			chain_d.cand_stamp = stamp_q;
			chain_d.cand_file  = file_q;
			chain_d.cand_page  = page_q;
		end
		if (fmatch) begin
			chain_d.any_drop = 1'b1;
		end
	end

	// Hand the partial search result to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else begin
			chain_q <= chain_d;
		end
	end

	assign chain_out = chain_q;

	// Apply the command's state change to this frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pinned_q <= 1'b0;
			dirty_q  <= 1'b0;
		end else if (cmd.commit) begin
			if (cmd.op == pblru_pkg::OP_DROP) begin
				if (fmatch) begin
					valid_q  <= 1'b0;
					pinned_q <= 1'b0;
					dirty_q  <= 1'b0;
				end
			end else if (me) begin
				if (cmd.fill) begin
					valid_q  <= 1'b1;
					pinned_q <= 1'b0;
					dirty_q  <= (cmd.op == pblru_pkg::OP_WRITE);
				end else begin
					unique case (cmd.op)
						pblru_pkg::OP_WRITE:  dirty_q  <= 1'b1;
						pblru_pkg::OP_FLUSH:  dirty_q  <= 1'b0;
						pblru_pkg::OP_PIN:    pinned_q <= 1'b1;
						pblru_pkg::OP_UNPIN:  pinned_q <= 1'b0;
						pblru_pkg::OP_REMOVE: begin
							valid_q  <= 1'b0;
							pinned_q <= 1'b0;
							dirty_q  <= 1'b0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && me && cmd.op != pblru_pkg::OP_DROP) begin
			if (cmd.fill) begin
				file_q <= cmd.file_id;
				page_q <= cmd.page_num;
			end
			if (cmd.op == pblru_pkg::OP_READ || cmd.op == pblru_pkg::OP_WRITE) begin
				stamp_q <= cmd.stamp;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/page_buffer_lru_pin_dirty.sv
// ----------------------------------------------------------------------------
// page_buffer_lru_pin_dirty
// Fully associative page-frame directory with LRU replacement and pinning.
// ----------------------------------------------------------------------------
// The accepting edge registers the request. During the scan every frame
// cell registers its part of the search, so the earliest match, earliest
// empty frame and oldest unpinned frame advance one cell per cycle and
// reach the end of the row. In the last scan cycle the marks and stamp
// are committed into the chosen cell and the result is captured. The
// result is presented from the following cycle and held until taken. A
// new request is taken only in the cycle after the result leaves, so a
// stalled consumer stops new requests and lengthens the request. Each
// cell holds one 32-bit stamp compare between registers. Reads and
// writes advance the use counter.
`timescale 1ns / 1ps
`default_nettype none
module page_buffer_lru_pin_dirty #(
	parameter int FRAMES = pblru_pkg::FRAMES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pblru_pkg::req_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pblru_pkg::rsp_t      out_data
);
	localparam int IDX_W = 6;
	localparam int CNT_W = $clog2(FRAMES + 1);

	pblru_pkg::state_t state_q, state_d;
	pblru_pkg::req_t   req_q;
	pblru_pkg::cmd_t   cmd;
	pblru_pkg::chain_t chain [FRAMES+1];
	pblru_pkg::chain_t tail_s1;
	pblru_pkg::rsp_t   rsp_d;
	logic [31:0]       clock_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic [IDX_W-1:0]  sel;
	logic              is_acc, fill, ok, last;

	// Hold the request; accept only when idle.
	assign in_ready = (state_q == pblru_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
	end

	// Last scan cycle: the chain tail has seen every frame.
	assign last = (state_q == pblru_pkg::S_SCAN) && (scan_cnt_q == CNT_W'(FRAMES));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pblru_pkg::S_IDLE: if (in_valid) state_d = pblru_pkg::S_SCAN;
			pblru_pkg::S_SCAN: if (last) state_d = pblru_pkg::S_DONE;
			pblru_pkg::S_DONE: if (out_ready) state_d = pblru_pkg::S_IDLE;
			default:           state_d = pblru_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pblru_pkg::S_IDLE;
			clock_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				scan_cnt_q <= '0;
			end else if (state_q == pblru_pkg::S_SCAN) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			if (last && is_acc) begin
				clock_q <= clock_q + 32'd1;
			end
		end
	end

	assign is_acc = (req_q.opcode == pblru_pkg::OP_READ) ||
		(req_q.opcode == pblru_pkg::OP_WRITE);

	// Chain head: nothing seen yet.
	assign chain[0] = '0;

	// Drive commands into the cell row.
	always_comb begin
		cmd          = '0;
		cmd.look     = (state_q == pblru_pkg::S_SCAN);
		cmd.commit   = last && ok;
		cmd.op       = req_q.opcode;
		cmd.fill     = fill;
		cmd.file_id  = req_q.file_id;
		cmd.page_num = req_q.page_num;
		cmd.stamp    = clock_q + 32'd1;
	end

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		pblru_cell #(
			.IDX_W (IDX_W),
			.INDEX (IDX_W'(g))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1])
		);
	end

	assign tail_s1 = chain[FRAMES];

	// Decide the frame and the result from the chain tail.
	always_comb begin
		rsp_d = '0;
		sel   = tail_s1.hit_idx;
		fill  = 1'b0;
		ok    = 1'b0;
		unique case (req_q.opcode)
			pblru_pkg::OP_READ, pblru_pkg::OP_WRITE: begin
				if (tail_s1.found) begin
					ok = 1'b1;
					rsp_d.frame = tail_s1.hit_idx[3:0];
					rsp_d.hit   = 1'b1;
				end else if (tail_s1.empty) begin
					ok = 1'b1; fill = 1'b1;
					sel = tail_s1.empty_idx;
					rsp_d.frame = tail_s1.empty_idx[3:0];
					rsp_d.fetch = 1'b1;
				end else if (tail_s1.cand) begin
					ok = 1'b1; fill = 1'b1;
					sel = tail_s1.cand_idx;
					rsp_d.frame     = tail_s1.cand_idx[3:0];
					rsp_d.fetch     = 1'b1;
					rsp_d.writeback = 1'b1;
					rsp_d.wb_file   = tail_s1.cand_file;
					rsp_d.wb_page   = tail_s1.cand_page;
				end else begin
					rsp_d.status = pblru_pkg::ST_PINNED;
				end
			end
			pblru_pkg::OP_FLUSH, pblru_pkg::OP_PIN, pblru_pkg::OP_UNPIN,
			pblru_pkg::OP_REMOVE: begin
				if (tail_s1.found) begin
					ok = 1'b1;
					rsp_d.frame = tail_s1.hit_idx[3:0];
					rsp_d.hit   = 1'b1;
					if (req_q.opcode == pblru_pkg::OP_FLUSH) begin
						rsp_d.writeback = 1'b1;
						rsp_d.wb_file   = req_q.file_id;
						rsp_d.wb_page   = req_q.page_num;
					end
				end else begin
					rsp_d.status = pblru_pkg::ST_ABSENT;
				end
			end
			pblru_pkg::OP_DROP: begin
				ok = 1'b1;
				rsp_d.hit = tail_s1.any_drop;
			end
			default: rsp_d.status = pblru_pkg::ST_ABSENT;
		endcase
	end

	// Hold the result until taken.
	always_ff @(posedge clk) begin
		if (last) begin
			out_data <= rsp_d;
		end
	end

	always_comb begin
		out_valid = (state_q == pblru_pkg::S_DONE);
	end
endmodule
`default_nettype wire

// File: hw/rtl/pblru_checker.sv
// ----------------------------------------------------------------------------
// pblru_checker
// Port-level checks of the page-frame directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_buffer_lru_pin_dirty_assert.svh"
module pblru_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire pblru_pkg::req_t in_data,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire pblru_pkg::rsp_t out_data
);
	// An accepted request starts the scan: no input and no result next cycle.
	`PB_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	// No new request while a result is pending.
	`PB_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	// Failure statuses carry no frame or flags.
	`PB_ASSERT_IMP(a_fail, clk, arst_n, out_valid && out_data.status != pblru_pkg::ST_OK,
		out_data.frame == 4'd0 && !out_data.hit && !out_data.fetch && !out_data.writeback)
	// Result held while stalled.
	`PB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
endmodule

bind page_buffer_lru_pin_dirty pblru_checker u_checker (.*);
`default_nettype wire

// File: tb/tb_page_buffer_lru_pin_dirty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_buffer_lru_pin_dirty
// Self-checking bench for the LRU page-frame directory with pin and dirty marks.
// ----------------------------------------------------------------------------
// A frame-table predictor tracks every frame's tags, marks and stamp and
// queues one expected response per accepted request. Directed tests cover
// fills, hits, LRU eviction, the all-pinned failure, flush, pin,
// unpin, remove, drop file, the unused opcode and field extremes. Random
// tests run page-access sequences over a small address pool, with bursty
// requests and, in the second run, a response side that stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_page_buffer_lru_pin_dirty;
	localparam int NFR = pblru_pkg::FRAMES_DEF;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pblru_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pblru_pkg::rsp_t out_data;

	// frame table as seen by the predictor
	logic        fv [NFR];
	logic [15:0] ff [NFR];
	logic [31:0] fp [NFR];
	logic        fpin [NFR];
	logic        fdirty [NFR];
	logic [31:0] fstamp [NFR];
	logic [31:0] access_count;

	pblru_pkg::rsp_t pending_rsp [$];
	int   errors = 0;
	int   cycles = 0;
	bit   hold_off = 1'b0;
	bit   stall_on = 1'b1;

	page_buffer_lru_pin_dirty dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int find_page(logic [15:0] f, logic [31:0] p);
		for (int i = 0; i < NFR; i++)
			if (fv[i] && ff[i] == f && fp[i] == p)
				return i;
		return -1;
	endfunction

	// Apply one request to the frame table and return the response it yields.
	function automatic pblru_pkg::rsp_t predict_frame_result(pblru_pkg::req_t rq);
		pblru_pkg::rsp_t r;
		int i;
		int victim;
		r = '0;
		victim = -1;
		case (pblru_pkg::op_t'(rq.opcode))
			pblru_pkg::OP_READ, pblru_pkg::OP_WRITE: begin
				access_count = access_count + 1;
				i = find_page(rq.file_id, rq.page_num);
				if (i >= 0) begin
					fstamp[i] = access_count;
					r.status = pblru_pkg::ST_OK; r.frame = i[3:0]; r.hit = 1'b1;
				end else begin
					for (int k = 0; k < NFR; k++)
						if (!fv[k] && victim < 0) victim = k;
					if (victim >= 0) begin
						r.status = pblru_pkg::ST_OK; r.frame = victim[3:0]; r.fetch = 1'b1;
					end else begin
						for (int k = 0; k < NFR; k++)
							if (!fpin[k] && (victim < 0 || fstamp[k] < fstamp[victim]))
								victim = k;
						if (victim < 0)
							r.status = pblru_pkg::ST_PINNED;
						else begin
							r.status = pblru_pkg::ST_OK; r.frame = victim[3:0];
							r.fetch = 1'b1; r.writeback = 1'b1;
							r.wb_file = ff[victim]; r.wb_page = fp[victim];
						end
					end
					if (victim >= 0) begin
						fv[victim] = 1'b1; ff[victim] = rq.file_id; fp[victim] = rq.page_num;
						fpin[victim] = 1'b0; fdirty[victim] = 1'b0;
						fstamp[victim] = access_count;
					end
					i = victim;
				end
				if (rq.opcode == pblru_pkg::OP_WRITE && i >= 0)
					fdirty[i] = 1'b1;
			end
			pblru_pkg::OP_FLUSH, pblru_pkg::OP_PIN, pblru_pkg::OP_UNPIN,
			pblru_pkg::OP_REMOVE: begin
				i = find_page(rq.file_id, rq.page_num);
				if (i < 0)
					r.status = pblru_pkg::ST_ABSENT;
				else begin
					r.status = pblru_pkg::ST_OK; r.frame = i[3:0]; r.hit = 1'b1;
					case (pblru_pkg::op_t'(rq.opcode))
						pblru_pkg::OP_FLUSH: begin
							fdirty[i] = 1'b0; r.writeback = 1'b1;
							r.wb_file = rq.file_id; r.wb_page = rq.page_num;
						end
						pblru_pkg::OP_PIN: fpin[i] = 1'b1;
						pblru_pkg::OP_UNPIN: fpin[i] = 1'b0;
						default: begin
							fv[i] = 1'b0; fpin[i] = 1'b0; fdirty[i] = 1'b0;
						end
					endcase
				end
			end
			pblru_pkg::OP_DROP: begin
				r.status = pblru_pkg::ST_OK;
				for (int k = 0; k < NFR; k++)
					if (fv[k] && ff[k] == rq.file_id) begin
						fv[k] = 1'b0; fpin[k] = 1'b0; fdirty[k] = 1'b0;
						r.hit = 1'b1;
					end
			end
			default: r.status = pblru_pkg::ST_ABSENT;
		endcase
		return r;
	endfunction

	// Offer one transaction at the falling edge, hold it until accepted.
	// Valid stays high afterwards; the caller drops it before an idle gap.
	task automatic send_request(pblru_pkg::op_t op, logic [15:0] f, logic [31:0] p);
		pblru_pkg::req_t rq;
		rq.opcode = op; rq.file_id = f; rq.page_num = p;
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (!in_ready);
		pending_rsp.push_back(predict_frame_result(rq));
		@(negedge clk);
	endtask

	// Bursty sender: a gap of random length between runs of back-to-back items.
	int burst_left = 0;
	task automatic paced_request(pblru_pkg::op_t op, logic [15:0] f, logic [31:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
			if (gap > 0)
				in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		send_request(op, f, p);
	endtask

	// Receiver: stall on its own pattern, with a long hold-off on demand.
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_off)
			out_ready <= 1'b0;
		else if (!stall_on)
			out_ready <= 1'b1;
		else
			out_ready <= ((stall_phase % 7) < 4) ? ($urandom_range(3, 0) != 0)
				: ($urandom_range(1, 0) == 1);
	end

	// Compare each accepted response against the oldest expected one.
	always @(posedge clk) begin
		pblru_pkg::rsp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %h", $time, out_data);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (out_data.status !== e.status || out_data.frame !== e.frame ||
				    out_data.hit !== e.hit || out_data.fetch !== e.fetch ||
				    out_data.writeback !== e.writeback ||
				    out_data.wb_file !== e.wb_file || out_data.wb_page !== e.wb_page) begin
					$display("%0t: mismatch expected st=%0d fr=%0d hit=%0b fe=%0b wb=%0b %h/%h",
						$time, e.status, e.frame, e.hit, e.fetch, e.writeback,
						e.wb_file, e.wb_page);
					$display("%0t:          actual st=%0d fr=%0d hit=%0b fe=%0b wb=%0b %h/%h",
						$time, out_data.status, out_data.frame, out_data.hit,
						out_data.fetch, out_data.writeback, out_data.wb_file,
						out_data.wb_page);
					errors++;
				end
			end
		end
	end

	// Fill every frame, hit, evict by age, then pin all and miss.
	task automatic test_fill_evict_pin();
		for (int i = 0; i < NFR; i++)
			send_request(pblru_pkg::OP_READ, 16'h0001, 32'(i));
		send_request(pblru_pkg::OP_WRITE, 16'h0001, 32'd0);   // hit, refresh frame 0, dirty
		send_request(pblru_pkg::OP_READ, 16'h0002, 32'd99);   // evicts frame 1 (oldest)
		for (int i = 0; i < NFR; i++)
			send_request(pblru_pkg::OP_PIN, (i == 1) ? 16'h0002 : 16'h0001,
				(i == 1) ? 32'd99 : 32'(i));
		send_request(pblru_pkg::OP_WRITE, 16'h0003, 32'd7);   // all pinned
		send_request(pblru_pkg::OP_UNPIN, 16'h0001, 32'd5);
		send_request(pblru_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF); // evicts frame 5
		send_request(pblru_pkg::OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(pblru_pkg::OP_FLUSH, 16'h0004, 32'd0);   // absent
		send_request(pblru_pkg::OP_REMOVE, 16'h0001, 32'd3);
		send_request(pblru_pkg::OP_REMOVE, 16'h0001, 32'd3);  // now absent
		send_request(pblru_pkg::OP_NONE, 16'h0001, 32'd4);
		send_request(pblru_pkg::OP_DROP, 16'h0001, 32'hAAAA_5555);
		send_request(pblru_pkg::OP_DROP, 16'h0001, 32'd0);    // nothing left to drop
		send_request(pblru_pkg::OP_DROP, 16'hFFFF, 32'd0);
		send_request(pblru_pkg::OP_READ, 16'h0000, 32'd0);    // fills lowest empty
		send_request(pblru_pkg::OP_DROP, 16'h0002, 32'd0);    // drops pinned frame
	endtask

	// Random access sequences on a small pool so hits, evictions and pins recur.
	task automatic test_random_traffic(int count);
		pblru_pkg::op_t op;
		logic [15:0] f;
		logic [31:0] p;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99, 0);
			if (sel < 40) op = pblru_pkg::OP_READ;
			else if (sel < 62) op = pblru_pkg::OP_WRITE;
			else if (sel < 70) op = pblru_pkg::OP_FLUSH;
			else if (sel < 78) op = pblru_pkg::OP_PIN;
			else if (sel < 87) op = pblru_pkg::OP_UNPIN;
			else if (sel < 94) op = pblru_pkg::OP_REMOVE;
			else if (sel < 98) op = pblru_pkg::OP_DROP;
			else op = pblru_pkg::OP_NONE;
			if ($urandom_range(15, 0) == 0) begin
				f = 16'($urandom); p = $urandom;
			end else begin
				f = ($urandom_range(1, 0) ? 16'hFFFF : 16'h0000) ^ 16'($urandom_range(3, 0));
				p = ($urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0) ^ 32'($urandom_range(11, 0));
			end
			paced_request(op, f, p);
		end
	endtask

	// Hold the response side off long enough for the block to fill and stall.
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_request(pblru_pkg::OP_READ, 16'h0003, 32'(i));
		join
		@(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < NFR; i++) begin
			fv[i] = 1'b0; ff[i] = '0; fp[i] = '0;
			fpin[i] = 1'b0; fdirty[i] = 1'b0; fstamp[i] = '0;
		end
		access_count = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_evict_pin();
		test_backpressure();
		stall_on = 1'b0;
		test_random_traffic(120);
		stall_on = 1'b1;
		test_random_traffic(260);
		in_valid <= 1'b0;
		// drain outstanding responses, then allow the pipeline to settle
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
